[rtl/fagq_pkg.sv]
// Shared types, constants and helper functions of the glyph quad generator.
package fagq_pkg;

   // Stream payload widths, padded to whole bytes.
   localparam int REQ_TDATA_W = 96;
   localparam int RSP_TDATA_W = 128;

   // Configuration port widths.
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   // Character codes and atlas geometry.
   localparam logic [15:0] GLYPH_FIRST = 16'd33;
   localparam logic [15:0] GLYPH_LAST  = 16'd132;
   localparam logic [15:0] LOWER_FIRST = 16'd97;
   localparam logic [15:0] LOWER_LAST  = 16'd122;
   localparam logic [15:0] CASE_SHIFT  = 16'd32;
   localparam logic [15:0] CODE_LF     = 16'd10;
   // The plus sign has atlas index ten, which the cursor logic also treats as a line feed.
   localparam logic [15:0] CODE_PLUS   = 16'd43;
   localparam int          ATLAS_COLS  = 10;
   localparam int          ATLAS_ROWS  = 10;
   localparam int          CELL_PITCH  = 25;
   localparam logic [7:0]  CELL_SPAN   = 8'd24;

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SCALE_X  = 2'd0,
      CSR_SCALE_Y  = 2'd1,
      CSR_OFFSET_X = 2'd2,
      CSR_OFFSET_Y = 2'd3
   } csr_index_type;

   // Texel corner of one atlas cell.
   typedef struct packed {
      logic [7:0] u;
      logic [7:0] v;
   } texel_type;

   // Saturate a signed 24-bit value to the signed 16-bit range.
   function automatic logic signed [15:0] sat16(input logic signed [23:0] val);
      logic signed [15:0] res;
      if (val > 24'sd32767) begin
         res = 16'sh7FFF;
      end else if (val < -24'sd32768) begin
         res = 16'sh8000;
      end else begin
         res = val[15:0];
      end
      return res;
   endfunction

   // Atlas cell position of a glyph index: the row is found by independent
   // compares against the row starts, the column is what remains.
   function automatic texel_type atlas_texel(input logic [6:0] idx);
      texel_type  res;
      logic [3:0] row;
      logic [6:0] col;
      row = 4'd0;
      for (int r = 1; r < ATLAS_ROWS; r++) begin
         if (idx >= 7'(r * ATLAS_COLS)) begin
            row = 4'(r);
         end
      end
      col   = idx - 7'(row) * 7'(ATLAS_COLS);
      res.u = 8'(col) * 8'(CELL_PITCH);
      res.v = 8'(row) * 8'(CELL_PITCH);
      return res;
   endfunction

endpackage

[rtl/font_atlas_glyph_quad_gen.sv]
// Top level of the glyph quad generator: cursor tracking, scaling pipeline and result register.
// Three register stages (A, B, result) lie between the character transfer and rsp_tvalid.
// Throughput: one character per cycle unless stalled; the cursor update is one saturating add.
// The scale multipliers and the rounding and offset logic each sit in their own stage.
// Characters without a glyph update the cursor and produce no transfer.
// Synchronous active-high reset clears the pipeline, the cursor and loads the default registers.
module font_atlas_glyph_quad_gen (
   input  logic                                clock,
   input  logic                                reset,
   // Request stream.
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // char_code[15:0], origin_x[31:16], origin_y[47:32], glyph_size[61:48],
   // quad_color[93:62], zero padding[95:94]
   input  logic [fagq_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // start_string[0]
   input  logic                                req_tuser,
   // Response stream.
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // x_left[15:0], x_right[31:16], y_top[47:32], y_bottom[63:48], u_left[71:64],
   // u_right[79:72], v_top[87:80], v_bottom[95:88], out_color[127:96]
   output logic [fagq_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   // Configuration write port.
   input  logic                                csr_we,
   input  logic [fagq_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [fagq_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import fagq_pkg::*;

   // Request fields.
   logic        [15:0] char_code;
   logic signed [15:0] origin_x;
   logic signed [15:0] origin_y;
   logic        [13:0] glyph_size;
   logic        [31:0] quad_color;
   logic               start_string;

   // Configuration registers.
   logic        [15:0] scale_x_ff,  scale_x_in;
   logic        [15:0] scale_y_ff,  scale_y_in;
   logic signed [15:0] offset_x_ff, offset_x_in;
   logic signed [15:0] offset_y_ff, offset_y_in;

   // Cursor state.
   logic signed [15:0] cursor_x_ff, cursor_x_in;
   logic signed [15:0] line_y_ff,   line_y_in;

   // Accept-side logic.
   logic               req_xfer;
   logic               is_glyph;
   logic               is_lower;
   logic               is_lf;
   logic signed [15:0] cx_eff;
   logic signed [15:0] ly_eff;
   logic signed [17:0] size_ext;
   logic signed [17:0] cx_sum;
   logic signed [17:0] ly_sum;
   logic signed [22:0] ypos_top;
   logic signed [22:0] ypos_bot;
   logic        [22:0] size_x7;
   logic        [15:0] glyph_code;
   logic        [6:0]  glyph_idx;
   texel_type          texel;

   // Stage A: positions.
   logic               a_vld_ff, a_vld_in;
   logic signed [17:0] a_xl_ff,  a_xr_ff;
   logic signed [22:0] a_yt_ff,  a_yb_ff;
   texel_type          a_tex_ff;
   logic        [31:0] a_color_ff;

   // Stage B: products.
   logic               b_vld_ff, b_vld_in;
   logic signed [34:0] b_pxl_ff, b_pxr_ff, b_pxl_in, b_pxr_in;
   logic signed [39:0] b_pyt_ff, b_pyb_ff, b_pyt_in, b_pyb_in;
   texel_type          b_tex_ff;
   logic        [31:0] b_color_ff;

   // Result register.
   logic                         o_vld_ff, o_vld_in;
   logic [RSP_TDATA_W-1:0]       o_data_ff, o_data_in;
   logic signed [34:0]           rnd_xl, rnd_xr;
   logic signed [39:0]           rnd_yt, rnd_yb;
   logic signed [23:0]           sum_xl, sum_xr, sum_yt, sum_yb;

   // Flow control.
   logic o_free, b_free, a_free;

   // Unpack the request.
   assign char_code    = req_tdata[15:0];
   assign origin_x     = req_tdata[31:16];
   assign origin_y     = req_tdata[47:32];
   assign glyph_size   = req_tdata[61:48];
   assign quad_color   = req_tdata[93:62];
   assign start_string = req_tuser;

   // Pipeline advance: a stage takes new data when it is empty or moves on.
   assign o_free     = !o_vld_ff || rsp_tready;
   assign b_free     = !b_vld_ff || o_free;
   assign a_free     = !a_vld_ff || b_free;
   assign req_tready = a_free;
   assign req_xfer   = req_tvalid && req_tready;

   // Character classification and atlas lookup.
   always_comb begin
      is_glyph   = (char_code >= GLYPH_FIRST) && (char_code <= GLYPH_LAST);
      is_lower   = (char_code >= LOWER_FIRST) && (char_code <= LOWER_LAST);
      is_lf      = (char_code == CODE_LF) || (char_code == CODE_PLUS);
      glyph_code = is_lower ? (char_code - CASE_SHIFT) : char_code;
      glyph_idx  = 7'(glyph_code - GLYPH_FIRST);
      texel      = atlas_texel(glyph_idx);
   end

   // Cursor positions for this character and the cursor left for the next one.
   always_comb begin
      cx_eff   = start_string ? origin_x : cursor_x_ff;
      ly_eff   = start_string ? origin_y : line_y_ff;
      size_ext = $signed({4'b0000, glyph_size});
      cx_sum   = 18'(cx_eff) + size_ext;
      ly_sum   = 18'(ly_eff) + size_ext;
      size_x7  = {6'b0, glyph_size, 3'b000} - {9'b0, glyph_size};
      // Vertical positions are kept five bits finer so lowercase insets stay exact.
      ypos_top = $signed({ly_eff[15], ly_eff[15], ly_eff, 5'b00000});
      ypos_bot = $signed({ly_sum, 5'b00000});
      if (is_lower) begin
         ypos_top = ypos_top + $signed(size_x7);
         ypos_bot = ypos_bot - $signed({9'b0, glyph_size});
      end
      if (is_lf) begin
         cursor_x_in = origin_x;
         line_y_in   = sat16(24'(ly_sum));
      end else begin
         cursor_x_in = sat16(24'(cx_sum));
         line_y_in   = ly_eff;
      end
   end

   // Configuration write decode.
   always_comb begin
      scale_x_in  = scale_x_ff;
      scale_y_in  = scale_y_ff;
      offset_x_in = offset_x_ff;
      offset_y_in = offset_y_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_SCALE_X:  scale_x_in  = csr_wdata;
            CSR_SCALE_Y:  scale_y_in  = csr_wdata;
            CSR_OFFSET_X: offset_x_in = $signed(csr_wdata);
            CSR_OFFSET_Y: offset_y_in = $signed(csr_wdata);
            default: ;
         endcase
      end
   end

   // Stage valids.
   always_comb begin
      a_vld_in = a_free ? (req_xfer && is_glyph) : a_vld_ff;
      b_vld_in = b_free ? a_vld_ff : b_vld_ff;
      o_vld_in = o_free ? b_vld_ff : o_vld_ff;
   end

   // Scaling products: one multiplier per edge.
   always_comb begin
      b_pxl_in = a_xl_ff * $signed({1'b0, scale_x_ff});
      b_pxr_in = a_xr_ff * $signed({1'b0, scale_x_ff});
      b_pyt_in = a_yt_ff * $signed({1'b0, scale_y_ff});
      b_pyb_in = a_yb_ff * $signed({1'b0, scale_y_ff});
   end

   // Round half up, translate and saturate each edge.
   always_comb begin
      rnd_xl = b_pxl_ff + 35'sd2048;
      rnd_xr = b_pxr_ff + 35'sd2048;
      rnd_yt = b_pyt_ff + 40'sd65536;
      rnd_yb = b_pyb_ff + 40'sd65536;
      sum_xl = $signed({rnd_xl[34], rnd_xl[34:12]}) + 24'(offset_x_ff);
      sum_xr = $signed({rnd_xr[34], rnd_xr[34:12]}) + 24'(offset_x_ff);
      sum_yt = $signed({rnd_yt[39], rnd_yt[39:17]}) + 24'(offset_y_ff);
      sum_yb = $signed({rnd_yb[39], rnd_yb[39:17]}) + 24'(offset_y_ff);
      o_data_in = {b_color_ff,
                   b_tex_ff.v + CELL_SPAN, b_tex_ff.v,
                   b_tex_ff.u + CELL_SPAN, b_tex_ff.u,
                   sat16(sum_yb), sat16(sum_yt), sat16(sum_xr), sat16(sum_xl)};
   end

   // Control state: configuration, cursor and stage valids.
   always_ff @(posedge clock) begin
      if (reset) begin
         scale_x_ff  <= 16'd4096;
         scale_y_ff  <= 16'd4096;
         offset_x_ff <= '0;
         offset_y_ff <= '0;
         cursor_x_ff <= '0;
         line_y_ff   <= '0;
         a_vld_ff    <= 1'b0;
         b_vld_ff    <= 1'b0;
         o_vld_ff    <= 1'b0;
      end else begin
         scale_x_ff  <= scale_x_in;
         scale_y_ff  <= scale_y_in;
         offset_x_ff <= offset_x_in;
         offset_y_ff <= offset_y_in;
         if (req_xfer) begin
            cursor_x_ff <= cursor_x_in;
            line_y_ff   <= line_y_in;
         end
         a_vld_ff <= a_vld_in;
         b_vld_ff <= b_vld_in;
         o_vld_ff <= o_vld_in;
      end
   end

   // Payload registers of the three stages.
   always_ff @(posedge clock) begin
      if (a_free) begin
         a_xl_ff    <= 18'(cx_eff);
         a_xr_ff    <= cx_sum;
         a_yt_ff    <= ypos_top;
         a_yb_ff    <= ypos_bot;
         a_tex_ff   <= texel;
         a_color_ff <= quad_color;
      end
      if (b_free) begin
         b_pxl_ff   <= b_pxl_in;
         b_pxr_ff   <= b_pxr_in;
         b_pyt_ff   <= b_pyt_in;
         b_pyb_ff   <= b_pyb_in;
         b_tex_ff   <= a_tex_ff;
         b_color_ff <= a_color_ff;
      end
      if (o_free) begin
         o_data_ff  <= o_data_in;
      end
   end

   assign rsp_tvalid = o_vld_ff;
   assign rsp_tdata  = o_data_ff;

endmodule

[rtl/fagq_checker.sv]
// Port-level checker of the glyph quad generator and its bind statement.
module fagq_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tready,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [fagq_pkg::RSP_TDATA_W-1:0]    rsp_tdata
);
   import fagq_pkg::*;

   // A stalled quad holds its value until it is transferred.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   // Reset empties the pipeline.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // Texel corners span one cell.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[79:72] == rsp_tdata[71:64] + CELL_SPAN)
                  && (rsp_tdata[95:88] == rsp_tdata[87:80] + CELL_SPAN))
      else $error("texel span mismatch");

   // Scales are unsigned and sizes non-negative, so edges never cross.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata[31:16]) >= $signed(rsp_tdata[15:0]))
                  && ($signed(rsp_tdata[63:48]) >= $signed(rsp_tdata[47:32])))
      else $error("quad edges out of order");

   // A free result register lets the request side through.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tready || !rsp_tvalid) |-> req_tready)
      else $error("request blocked with room in the pipeline");

endmodule

bind font_atlas_glyph_quad_gen fagq_checker u_fagq_checker (.*);
